// ----- rtl/core/lsch_pkg.sv -----
// lottery scheduler package: sequencer states, field widths and table word layout
// no dependencies; imported by lottery_scheduler_top
`default_nettype none

package lsch_pkg;

	// fixed field widths
	localparam int SLOT_W   = 4;
	localparam int BURST_W  = 16;
	localparam int TICKET_W = 8;
	localparam int DRAW_W   = 16;
	localparam int COUNT_W  = 5;
	localparam int TICK_W   = 20;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	// input action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// slot table word: remaining work, original burst, tickets
	localparam int WORD_W  = 2 * BURST_W + TICKET_W;
	localparam int REM_LSB = BURST_W + TICKET_W;
	localparam int ORG_LSB = TICKET_W;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_WALK,
		ST_UPD,
		ST_FIN
	} lsch_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/lsch_ram.sv -----
// generic single write port ram with registered read
// no dependencies; holds the lottery scheduler slot table
`default_nettype none

module lsch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/lottery_scheduler_top.sv -----
// lottery scheduler top level: sequencer, ticket accumulator, bit-serial divider
// depends on lsch_pkg and lsch_ram
`default_nettype none

// sequence: a load word goes straight to the result register; a tick word runs a sum
//   pass over the active slots, 16 divider steps, a walk pass that stops at the winner,
//   an update and the result; both table passes go through the single read port
// throughput: one word at a time; input stall stays high until the result is registered
// reset: finished flags, tick counter, sequencer and output valid clear; slot count is 1
module lottery_scheduler_top import lsch_pkg::*; #(
	parameter int MAX_SLOTS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                cfg_we,
	input  wire logic [COUNT_W-1:0]  cfg_wdata,
	// input channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                action,
	input  wire logic [SLOT_W-1:0]   slot,
	input  wire logic [BURST_W-1:0]  burst_length,
	input  wire logic [TICKET_W-1:0] ticket_weight,
	input  wire logic [DRAW_W-1:0]   random_value,
	// output channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [SLOT_W-1:0]        winner_slot,
	output logic                     served,
	output logic                     completed,
	output logic [TICK_W-1:0]        finish_tick,
	output logic [TICK_W-1:0]        waiting_time,
	output logic                     all_finished
);

	localparam int SW   = $clog2(MAX_SLOTS);
	localparam int CW   = $clog2(MAX_SLOTS + 1);
	localparam int SUMW = $clog2(MAX_SLOTS * (2 ** TICKET_W - 1) + 1);
	localparam int DCW  = $clog2(DRAW_W);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(DRAW_W - 1);

	lsch_state_t state_q, state_d;

	logic [COUNT_W-1:0]   count_q;
	logic [MAX_SLOTS-1:0] fin_flags_q;
	logic [TICK_W-1:0]    tick_q;

	logic [CW-1:0]        idx_q;
	logic                 rd_v_s1;
	logic [SW-1:0]        rd_idx_s1;
	logic [SUMW-1:0]      acc_q;
	logic [SUMW-1:0]      div_rem_q;
	logic [DRAW_W-1:0]    div_dvd_q;
	logic [DCW-1:0]       div_cnt_q;
	logic [SW-1:0]        win_idx_q;
	logic [WORD_W-1:0]    win_word_q;

	logic [SLOT_W-1:0]    res_slot_q;
	logic                 res_served_q;
	logic                 res_done_q;
	logic [TICK_W-1:0]    res_fin_q;
	logic [TICK_W-1:0]    res_wait_q;

	logic                 out_valid_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic                 out_served_q;
	logic                 out_done_q;
	logic [TICK_W-1:0]    out_fin_q;
	logic [TICK_W-1:0]    out_wait_q;
	logic                 out_all_q;

	logic [CW-1:0]        n_eff;
	logic [MAX_SLOTS-1:0] act_mask;
	logic                 all_fin;
	logic                 in_fire;
	logic                 load_ok;
	logic [SW-1:0]        load_addr;
	logic                 issue;
	logic                 pass_done;
	logic                 rd_live;
	logic [TICKET_W-1:0]  rd_tk;
	logic [SUMW-1:0]      acc_sum;
	logic                 hit;
	logic                 fin_load;
	logic [WORD_W-1:0]    rd_word;

	logic                 ram_we;
	logic [SW-1:0]        ram_waddr;
	logic [WORD_W-1:0]    ram_wdata;

	logic [SUMW:0]        div_shift;
	logic [SUMW:0]        div_trial;
	logic [SUMW-1:0]      div_next;

	logic [BURST_W-1:0]   rem_new;
	logic [BURST_W-1:0]   org_burst;
	logic [TICK_W-1:0]    tick_new;
	logic [TICK_W-1:0]    org_ext;

	// slot table
	lsch_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q[SW-1:0]),
		.rdata(rd_word)
	);

	// effective slot count, clamped to 1..MAX_SLOTS
	always_comb begin
		if (count_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(count_q) > MAX_SLOTS) begin
			n_eff = CW'(MAX_SLOTS);
		end else begin
			n_eff = CW'(count_q);
		end
	end

	// active slot mask and all-finished test
	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			act_mask[i] = (i < int'(n_eff));
		end
	end

	assign all_fin = &(fin_flags_q | ~act_mask);

	// handshake and table pass control
	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign load_ok   = (32'(slot) < MAX_SLOTS);
	assign load_addr = SW'(slot);
	assign issue     = ((state_q == ST_SUM) || (state_q == ST_WALK)) && (idx_q < n_eff);
	assign pass_done = !issue && !rd_v_s1;
	assign rd_live   = rd_v_s1 && !fin_flags_q[rd_idx_s1];
	assign rd_tk     = rd_word[TICKET_W-1:0];

	// shared accumulator adder: ticket sum, then running sum in the walk
	assign acc_sum = acc_q + SUMW'(rd_tk);
	assign hit     = rd_live && (div_rem_q < acc_sum);

	// divider step: restoring, one draw bit per cycle, divisor held in acc_q
	assign div_shift = {div_rem_q, div_dvd_q[DRAW_W-1]};
	assign div_trial = div_shift - {1'b0, acc_q};
	assign div_next  = (div_shift >= {1'b0, acc_q}) ? div_trial[SUMW-1:0]
	                                                : div_shift[SUMW-1:0];

	// winner update arithmetic
	assign rem_new   = win_word_q[REM_LSB +: BURST_W] - BURST_W'(1);
	assign org_burst = win_word_q[ORG_LSB +: BURST_W];
	assign tick_new  = (tick_q == TICK_MAX) ? tick_q : tick_q + TICK_W'(1);
	assign org_ext   = TICK_W'(org_burst);

	// table write port: load word or winner write-back
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = load_addr;
		ram_wdata = {burst_length, burst_length, ticket_weight};
		if (state_q == ST_UPD) begin
			ram_we    = 1'b1;
			ram_waddr = win_idx_q;
			ram_wdata = {rem_new, org_burst, win_word_q[TICKET_W-1:0]};
		end else if (in_fire && (action == ACT_LOAD) && load_ok) begin
			ram_we = 1'b1;
		end
	end

	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if ((action == ACT_LOAD) || all_fin) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_SUM;
					end
				end
			end
			ST_SUM: begin
				if (pass_done) begin
					state_d = (acc_q == '0) ? ST_FIN : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (hit) begin
					state_d = ST_UPD;
				end else if (pass_done) begin
					state_d = ST_FIN;
				end
			end
			ST_UPD: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (fin_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_W'(1);
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// finished flags and tick counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_flags_q <= '0;
			tick_q      <= '0;
		end else if (in_fire && (action == ACT_LOAD)) begin
			tick_q <= '0;
			if (load_ok) begin
				fin_flags_q[load_addr] <= (burst_length == '0);
			end
		end else if (state_q == ST_UPD) begin
			tick_q <= tick_new;
			if (rem_new == '0) begin
				fin_flags_q[win_idx_q] <= 1'b1;
			end
		end
	end

	// table read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[SW-1:0];
	end

	// datapath: index, accumulator, divider, winner capture, result fields
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q        <= '0;
				acc_q        <= '0;
				div_rem_q    <= '0;
				div_cnt_q    <= '0;
				div_dvd_q    <= random_value;
				res_slot_q   <= '0;
				res_served_q <= 1'b0;
				res_done_q   <= 1'b0;
				res_fin_q    <= '0;
				res_wait_q   <= '0;
			end
			ST_SUM: begin
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end else if (!rd_v_s1) begin
					idx_q <= '0;
				end
				if (rd_live) begin
					acc_q <= acc_sum;
				end
			end
			ST_DIV: begin
				div_rem_q <= div_next;
				div_dvd_q <= {div_dvd_q[DRAW_W-2:0], 1'b0};
				div_cnt_q <= div_cnt_q + DCW'(1);
				if (div_cnt_q == DIV_LAST) begin
					acc_q <= '0;
				end
			end
			ST_WALK: begin
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (rd_live) begin
					acc_q <= acc_sum;
				end
				if (hit) begin
					win_idx_q  <= rd_idx_s1;
					win_word_q <= rd_word;
				end
			end
			ST_UPD: begin
				res_slot_q   <= SLOT_W'(win_idx_q);
				res_served_q <= 1'b1;
				if (rem_new == '0) begin
					res_done_q <= 1'b1;
					res_fin_q  <= tick_new;
					res_wait_q <= (tick_new >= org_ext) ? tick_new - org_ext : '0;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_slot_q   <= res_slot_q;
			out_served_q <= res_served_q;
			out_done_q   <= res_done_q;
			out_fin_q    <= res_fin_q;
			out_wait_q   <= res_wait_q;
			out_all_q    <= all_fin;
		end
	end

	assign out_valid    = out_valid_q;
	assign winner_slot  = out_slot_q;
	assign served       = out_served_q;
	assign completed    = out_done_q;
	assign finish_tick  = out_fin_q;
	assign waiting_time = out_wait_q;
	assign all_finished = out_all_q;

endmodule

`default_nettype wire

// ----- tb/lottery_scheduler_top_test.sv -----
// self-checking bench for lottery_scheduler_top: queued load/tick words, a local
// scheduler predictor, random sender gaps and receiver stalls, idle-cycle watchdog
// depends on lsch_pkg and lottery_scheduler_top
`timescale 1ns / 1ps

module lottery_scheduler_top_test;
	import lsch_pkg::*;

	localparam int SLOTS      = 16;
	localparam int DRAIN_WAIT = 64;
	localparam int IDLE_LIMIT = 2000;
	localparam int WORD_GOAL  = 1150;

	typedef struct packed {
		logic                act;
		logic [SLOT_W-1:0]   slot;
		logic [BURST_W-1:0]  burst;
		logic [TICKET_W-1:0] tickets;
		logic [DRAW_W-1:0]   draw;
	} sched_word_t;

	typedef struct packed {
		logic [SLOT_W-1:0] winner;
		logic              served;
		logic              completed;
		logic [TICK_W-1:0] fin;
		logic [TICK_W-1:0] waited;
		logic              all_fin;
	} sched_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	sched_word_t cur_word = '0;

	logic in_stall;
	logic out_valid;
	logic [SLOT_W-1:0] winner_slot;
	logic served;
	logic completed;
	logic [TICK_W-1:0] finish_tick;
	logic [TICK_W-1:0] waiting_time;
	logic all_finished;

	// predictor state: mirror of the slot table, flags, tick counter and count register
	logic [BURST_W-1:0]  work_left [SLOTS];
	logic [BURST_W-1:0]  burst_len [SLOTS];
	logic [TICKET_W-1:0] ticket_of [SLOTS];
	logic                slot_done [SLOTS];
	logic [TICK_W-1:0]   tick_now = '0;
	logic [COUNT_W-1:0]  proc_count = 5'd1;

	sched_word_t pending_q[$];
	sched_res_t  sched_results_q[$];
	sched_res_t  head_res;

	logic word_taken = 1'b0;
	int   feed_gap = 0;
	bit   feed_calm = 1'b0;
	int   sink_wait = 0;
	bit   sink_calm = 1'b0;
	int   idle_cycles = 0;
	int   mismatches = 0;
	int   words_queued = 0;

	lottery_scheduler_top #(.MAX_SLOTS(SLOTS)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (cur_word.act),
		.slot         (cur_word.slot),
		.burst_length (cur_word.burst),
		.ticket_weight(cur_word.tickets),
		.random_value (cur_word.draw),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.winner_slot  (winner_slot),
		.served       (served),
		.completed    (completed),
		.finish_tick  (finish_tick),
		.waiting_time (waiting_time),
		.all_finished (all_finished)
	);

	always #2 clk = ~clk;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			work_left[i] = '0;
			burst_len[i] = '0;
			ticket_of[i] = '0;
			slot_done[i] = 1'b0;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic int active_slots();
		if (proc_count == '0)
			return 1;
		if (proc_count > SLOTS)
			return SLOTS;
		return int'(proc_count);
	endfunction

	function automatic bit every_slot_done(input int n);
		for (int i = 0; i < n; i++)
			if (!slot_done[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// apply one word to the mirrored state and return the result it should produce
	function automatic sched_res_t schedule_word(input sched_word_t w);
		sched_res_t  r;
		int unsigned n;
		int unsigned pool;
		int unsigned run;
		int unsigned pick;
		int          win_idx;
		bit          hit;
		r = '0;
		hit = 1'b0;
		win_idx = 0;
		n = active_slots();
		if (w.act == ACT_LOAD) begin
			work_left[w.slot] = w.burst;
			burst_len[w.slot] = w.burst;
			ticket_of[w.slot] = w.tickets;
			slot_done[w.slot] = (w.burst == '0);
			tick_now = '0;
		end else if (!every_slot_done(n)) begin
			// ticket pool of unfinished slots
			pool = 0;
			for (int i = 0; i < n; i++)
				if (!slot_done[i])
					pool += ticket_of[i];
			if (pool != 0) begin
				// walk the running ticket sum to find the winner
				pick = w.draw % pool;
				run = 0;
				for (int i = 0; i < n && !hit; i++) begin
					if (!slot_done[i]) begin
						run += ticket_of[i];
						if (pick < run) begin
							hit = 1'b1;
							win_idx = i;
						end
					end
				end
				if (hit) begin
					r.winner = win_idx[SLOT_W-1:0];
					r.served = 1'b1;
					work_left[win_idx] = work_left[win_idx] - BURST_W'(1);
					if (tick_now != TICK_MAX)
						tick_now = tick_now + TICK_W'(1);
					if (work_left[win_idx] == '0) begin
						slot_done[win_idx] = 1'b1;
						r.completed = 1'b1;
						r.fin = tick_now;
						// a restart mid-run can leave the counter below the burst
						r.waited = (tick_now >= TICK_W'(burst_len[win_idx])) ?
							tick_now - TICK_W'(burst_len[win_idx]) : '0;
					end
				end
			end
		end
		r.all_fin = every_slot_done(n);
		return r;
	endfunction

	// ---------------------------------------------------------------- pacing

	function automatic int pace(input bit calm);
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	// ---------------------------------------------------------------- driver

	// input word accepted: predict it and draw the gap before the next one
	always @(posedge clk) begin
		if (arst_n) begin
			word_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				sched_results_q.push_back(schedule_word(cur_word));
				feed_gap <= pace(feed_calm);
				if ($urandom_range(0, 39) == 0)
					feed_calm = !feed_calm;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !word_taken) begin
				// stalled word holds
			end else if (feed_gap != 0) begin
				in_valid <= 1'b0;
				feed_gap <= feed_gap - 1;
			end else if (pending_q.size() != 0) begin
				cur_word <= pending_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic check_field(input string fname, input logic [TICK_W-1:0] want,
			input logic [TICK_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			if (!out_stall) begin
				if (sched_results_q.size() == 0) begin
					$display("%0t: result word with none expected, expected nothing, got slot %0d",
						$time, winner_slot);
					mismatches++;
				end else begin
					head_res = sched_results_q.pop_front();
					check_field("winner_slot", TICK_W'(head_res.winner), TICK_W'(winner_slot));
					check_field("served", TICK_W'(head_res.served), TICK_W'(served));
					check_field("completed", TICK_W'(head_res.completed), TICK_W'(completed));
					check_field("finish_tick", head_res.fin, finish_tick);
					check_field("waiting_time", head_res.waited, waiting_time);
					check_field("all_finished", TICK_W'(head_res.all_fin),
						TICK_W'(all_finished));
				end
				sink_wait <= pace(sink_calm);
				if ($urandom_range(0, 39) == 0)
					sink_calm = !sink_calm;
			end else if (sink_wait != 0) begin
				sink_wait <= sink_wait - 1;
			end
		end
	end

	// receiver stall, counted down only while a result is offered
	always @(negedge clk) begin
		out_stall <= arst_n && (sink_wait != 0);
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
				$display("lottery_scheduler_top_test: done, errors");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic queue_load(input int s, input int b, input int tk);
		sched_word_t w;
		w = '0;
		w.act = ACT_LOAD;
		w.slot = s[SLOT_W-1:0];
		w.burst = b[BURST_W-1:0];
		w.tickets = tk[TICKET_W-1:0];
		w.draw = DRAW_W'($urandom_range(0, 65535));
		pending_q.push_back(w);
		words_queued++;
	endtask

	task automatic queue_tick(input int d);
		sched_word_t w;
		w = '0;
		w.act = ACT_TICK;
		w.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
		w.burst = BURST_W'($urandom_range(0, 65535));
		w.tickets = TICKET_W'($urandom_range(0, 255));
		w.draw = d[DRAW_W-1:0];
		pending_q.push_back(w);
		words_queued++;
	endtask

	function automatic int pick_tickets();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 255;
			2: return $urandom_range(1, 3);
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// wait until the sender has nothing left and every result has come back
	task automatic wait_quiet();
		while (pending_q.size() != 0 || in_valid || sched_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_proc_count(input int c);
		wait_quiet();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c[COUNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		proc_count = c[COUNT_W-1:0];
	endtask

	// one round: load every active slot, then tick until the work should be done
	task automatic queue_round(input int n);
		int total;
		int ticks;
		int b;
		int d;
		total = 0;
		for (int s = 0; s < n; s++) begin
			case ($urandom_range(0, 19))
				0, 1: b = 0;
				2: b = $urandom_range(0, 65535);
				default: b = $urandom_range(1, 6);
			endcase
			if (b <= 6)
				total += b;
			queue_load(s, b, pick_tickets());
		end
		// stray load outside the active range
		if (n < SLOTS && $urandom_range(0, 3) == 0)
			queue_load($urandom_range(n, SLOTS - 1), $urandom_range(0, 65535), pick_tickets());
		ticks = total + $urandom_range(0, 3);
		if (ticks > 150)
			ticks = 150;
		for (int t = 0; t < ticks; t++) begin
			// occasional reload mid-run restarts the tick counter
			if ($urandom_range(0, 29) == 0)
				queue_load($urandom_range(0, n - 1), $urandom_range(1, 4), pick_tickets());
			case ($urandom_range(0, 9))
				0: d = 0;
				1: d = 65535;
				default: d = $urandom_range(0, 65535);
			endcase
			queue_tick(d);
		end
	endtask

	initial begin
		int c;
		int n;
		int round_idx;
		round_idx = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single slot at reset count: zero burst, idle ticks, extreme burst and draws
		queue_load(0, 0, 255);
		queue_tick(1234);
		queue_load(0, 2, 0);
		queue_tick(77);
		queue_load(0, 65535, 255);
		queue_tick(65535);
		queue_load(0, 2, 128);
		queue_tick(0);
		queue_tick(12345);

		// two slots: lopsided tickets, reload mid-run, late completion, empty pool
		set_proc_count(2);
		queue_load(0, 3, 1);
		queue_load(1, 1, 255);
		queue_tick(0);
		queue_tick(65535);
		queue_load(1, 4, 0);
		queue_tick(0);
		queue_tick(0);
		queue_tick(7);

		// random rounds, extremes of the count first
		while (words_queued < WORD_GOAL) begin
			case (round_idx)
				0: c = 0;
				1: c = 31;
				2: c = 16;
				3: c = 17;
				4: c = 1;
				default: c = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(0, 31);
			endcase
			round_idx++;
			set_proc_count(c);
			n = (c == 0) ? 1 : (c > SLOTS) ? SLOTS : c;
			queue_round(n);
		end

		wait_quiet();
		if (sched_results_q.size() != 0) begin
			$display("%0t: %0d results never arrived, expected 0 left", $time,
				sched_results_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("lottery_scheduler_top_test: done, clean");
		else
			$display("lottery_scheduler_top_test: done, errors");
		$finish;
	end

endmodule
